>>> rtl/colour_histogram_block_probability_top_defines.svh
// assertion macros used by the sequencer chbp_ctrl
`ifndef COLOUR_HISTOGRAM_BLOCK_PROBABILITY_TOP_DEFINES_SVH
`define COLOUR_HISTOGRAM_BLOCK_PROBABILITY_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define CHBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define CHBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/chbp_pkg.sv
// constants, types and helpers of the colour histogram block probability unit
package chbp_pkg;

  localparam int HIST_ENTRIES = 4096;
  localparam int ADDR_W       = $clog2(HIST_ENTRIES);
  localparam int COUNT_CAP    = 100;
  localparam int COUNT_W      = 7;
  localparam int BLOCK_PIXELS = 16;
  localparam int SUM_LIMIT    = BLOCK_PIXELS * COUNT_CAP;
  localparam int SUM_W        = $clog2(SUM_LIMIT + 1);
  localparam int TP_W         = 21;
  localparam int PROB_W       = 8;
  localparam int FULL_SCALE   = 255;
  localparam int NUM_W        = SUM_W + PROB_W;
  localparam int DCNT_W       = $clog2(NUM_W);

  typedef enum logic [1:0] {
    REQ_TRAIN = 2'd0,
    REQ_LEAK  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [NUM_W-1:0] num;
    logic [TP_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROB_W-1:0] prob;
    logic              sat;
  } div_rsp_t;

  // 4 bits per channel, red in the top nibble
  function automatic logic [ADDR_W-1:0] bin_of(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    logic [11:0] full;
    full = {r[7:4], g[7:4], b[7:4]};
    return ADDR_W'(full % HIST_ENTRIES);
  endfunction

endpackage

>>> rtl/chbp_req_if.sv
// request channel: pixel items with their request type
interface chbp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_of_block;

  modport source (output valid, req_type, red, green, blue, last_of_block, input ready);
  modport sink   (input valid, req_type, red, green, blue, last_of_block, output ready);
endinterface

>>> rtl/chbp_res_if.sv
// result channel: one probability item per closed block
interface chbp_res_if import chbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic              saturated;

  modport source (output valid, probability, saturated, input ready);
  modport sink   (input valid, probability, saturated, output ready);
endinterface

>>> rtl/colour_histogram_block_probability_top.sv
// Colour histogram back-projection: a train item is accepted, then its bin gets a
// read-modify-write in the 4096 x 7 bit histogram memory through its registered
// read port; a query item reads its bin and adds it to the block sum, and a query
// that closes a block then waits for the 19-step restoring divider that forms
// floor(255*sum/divisor) with the configured divisor. A leak item sweeps every bin
// through the memory port. After reset a clearing pass zeroes the histogram, during
// which no item is accepted. A finished result waits in an output register while
// the next item is taken.
module colour_histogram_block_probability_top import chbp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [TP_W-1:0] cfg_wdata_i,
  chbp_req_if.sink        req_i,
  chbp_res_if.source      res_o
);

  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic [COUNT_W-1:0] mem_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  chbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .res_o       (res_o),
    .mem_wr_o    (mem_wr),
    .mem_rd_o    (mem_rd),
    .mem_rdata_i (mem_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  chbp_hist_mem u_hist_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  chbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

>>> rtl/chbp_hist_mem.sv
// histogram bin storage, one write and one registered read port
module chbp_hist_mem import chbp_pkg::*; (
  input  logic               clk_i,
  input  mem_wr_t            wr_i,
  input  mem_rd_t            rd_i,
  output logic [COUNT_W-1:0] rdata_o
);

  logic [COUNT_W-1:0] mem [HIST_ENTRIES];
  logic [COUNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/chbp_div.sv
// restoring divider, one quotient bit per cycle, result clipped to 8 bits
module chbp_div import chbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_HOLD
  } dv_state_e;

  dv_state_e          state_q, state_d;
  logic [DCNT_W-1:0]  cnt_q, cnt_d;
  logic [TP_W-1:0]    rem_q, rem_d;
  logic [TP_W-1:0]    den_q, den_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [TP_W:0]      trial;
  logic               fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    num_d   = num_q;
    quo_d   = quo_q;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          state_d = DV_RUN;
          cnt_d   = DCNT_W'(NUM_W - 1);
          rem_d   = '0;
          den_d   = req_i.den;
          num_d   = req_i.num;
          quo_d   = '0;
        end
      end
      DV_RUN: begin
        rem_d = fits ? TP_W'(trial - {1'b0, den_q}) : trial[TP_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], fits};
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = DV_HOLD;
        end
      end
      DV_HOLD: begin
        if (req_i.ack) begin
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = state_q != DV_IDLE;
  assign rsp_o.done = state_q == DV_HOLD;
  assign rsp_o.sat  = |quo_q[NUM_W-1:PROB_W];
  assign rsp_o.prob = rsp_o.sat ? PROB_W'(FULL_SCALE) : quo_q[PROB_W-1:0];

endmodule

>>> rtl/chbp_ctrl.sv
// sequencer: clear pass, read-modify-write of bins, leak sweep, block sum and result
`include "colour_histogram_block_probability_top_defines.svh"
module chbp_ctrl import chbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TP_W-1:0]    cfg_wdata_i,
  chbp_req_if.sink           req_i,
  chbp_res_if.source         res_o,
  output mem_wr_t            mem_wr_o,
  output mem_rd_t            mem_rd_o,
  input  logic [COUNT_W-1:0] mem_rdata_i,
  output div_req_t           div_req_o,
  input  div_rsp_t           div_rsp_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WAIT,
    ST_LEAK_RD,
    ST_LEAK_END
  } state_e;

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(HIST_ENTRIES - 1);

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic               wr_pend_q, wr_pend_d;
  logic [1:0]         req_q, req_d;
  logic               last_q, last_d;
  logic [ADDR_W-1:0]  bin_q, bin_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [TP_W-1:0]    tp_q, tp_d;
  logic               out_valid_q, out_valid_d;
  logic [PROB_W-1:0]  prob_q, prob_d;
  logic               sat_q, sat_d;

  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] cnt_dec;

  assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(mem_rdata_i);
  assign sum_next = (sum_wide > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_W'(SUM_LIMIT)
                                                          : sum_wide[SUM_W-1:0];
  assign cnt_dec  = (mem_rdata_i == '0) ? '0 : mem_rdata_i - 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wr_pend_d   = wr_pend_q;
    req_d       = req_q;
    last_d      = last_q;
    bin_d       = bin_q;
    sum_d       = sum_q;
    tp_d        = cfg_we_i ? cfg_wdata_i : tp_q;
    out_valid_d = out_valid_q && !res_o.ready;
    prob_d      = prob_q;
    sat_d       = sat_q;
    mem_wr_o    = '0;
    mem_rd_o    = '0;
    div_req_o.start = 1'b0;
    div_req_o.ack   = 1'b0;
    // 255 * sum as shift and subtract
    div_req_o.num   = {sum_next, {PROB_W{1'b0}}} - NUM_W'(sum_next);
    div_req_o.den   = (tp_q == '0) ? TP_W'(1) : tp_q;

    case (state_q)
      ST_CLEAR: begin
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = cnt_q;
        mem_wr_o.data = '0;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = bin_of(req_i.red, req_i.green, req_i.blue);
        if (req_i.valid) begin
          req_d  = req_i.req_type;
          last_d = req_i.last_of_block;
          bin_d  = mem_rd_o.addr;
          case (req_i.req_type)
            REQ_TRAIN, REQ_QUERY: state_d = ST_MOD;
            REQ_LEAK: begin
              state_d   = ST_LEAK_RD;
              cnt_d     = '0;
              wr_pend_d = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MOD: begin
        state_d = ST_IDLE;
        if (req_q == REQ_TRAIN) begin
          mem_wr_o.en   = mem_rdata_i < COUNT_W'(COUNT_CAP);
          mem_wr_o.addr = bin_q;
          mem_wr_o.data = mem_rdata_i + 1'b1;
        end else if (last_q) begin
          div_req_o.start = 1'b1;
          sum_d           = '0;
          state_d         = ST_WAIT;
        end else begin
          sum_d = sum_next;
        end
      end
      ST_WAIT: begin
        if (div_rsp_i.done && (!out_valid_q || res_o.ready)) begin
          div_req_o.ack = 1'b1;
          out_valid_d   = 1'b1;
          prob_d        = div_rsp_i.prob;
          sat_d         = div_rsp_i.sat;
          state_d       = ST_IDLE;
        end
      end
      ST_LEAK_RD: begin
        // read bin n while writing back bin n-1
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = cnt_q;
        mem_wr_o.en   = wr_pend_q;
        mem_wr_o.addr = cnt_q - 1'b1;
        mem_wr_o.data = cnt_dec;
        wr_pend_d     = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = ST_LEAK_END;
        end
      end
      ST_LEAK_END: begin
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = cnt_q - 1'b1;
        mem_wr_o.data = cnt_dec;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      sum_q       <= '0;
      tp_q        <= TP_W'(1);
      out_valid_q <= 1'b0;
      req_q       <= '0;
      last_q      <= 1'b0;
      bin_q       <= '0;
      prob_q      <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wr_pend_q   <= wr_pend_d;
      sum_q       <= sum_d;
      tp_q        <= tp_d;
      out_valid_q <= out_valid_d;
      req_q       <= req_d;
      last_q      <= last_d;
      bin_q       <= bin_d;
      prob_q      <= prob_d;
      sat_q       <= sat_d;
    end
  end

  assign req_i.ready       = state_q == ST_IDLE;
  assign res_o.valid       = out_valid_q;
  assign res_o.probability = prob_q;
  assign res_o.saturated   = sat_q;

  `CHBP_ASSERT(a_sum_limit, sum_q <= SUM_W'(SUM_LIMIT), "block sum above limit")
  `CHBP_ASSERT(a_bin_cap, mem_wr_o.en |-> mem_wr_o.data <= COUNT_W'(COUNT_CAP), "bin above cap")
  `CHBP_ASSERT_NEVER(a_div_overlap, div_req_o.start && div_rsp_i.busy, "divider started twice")
  `CHBP_ASSERT(a_sum_cleared,
    (state_q == ST_MOD && req_q == REQ_QUERY && last_q) |=> sum_q == '0,
    "block sum not cleared after result")

endmodule

>>> dv/chbp_backproject_checker.sv
// checker: predicts block probabilities from accepted pixel items and compares results
`timescale 1ns / 100ps

module chbp_backproject_checker import chbp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [TP_W-1:0] cfg_wdata_i,
  chbp_req_if             req,
  chbp_res_if             res,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              saturated;
  } block_value_t;

  logic [COUNT_W-1:0] bin_count [HIST_ENTRIES];
  logic [SUM_W-1:0]   running_sum;
  logic [TP_W-1:0]    divisor;
  block_value_t       block_values_q [$];
  block_value_t       want;
  int                 mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_pixel(input logic [1:0] kind, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic last);
    int unsigned  bin;
    int unsigned  total;
    int unsigned  den;
    int unsigned  val;
    block_value_t v;
    bin = ((int'(r) >> 4) * 256 + (int'(g) >> 4) * 16 + (int'(b) >> 4)) % HIST_ENTRIES;
    case (kind)
      REQ_TRAIN: begin
        if (bin_count[bin] < COUNT_CAP) bin_count[bin] = bin_count[bin] + 1'b1;
      end
      REQ_LEAK: begin
        foreach (bin_count[i]) begin
          if (bin_count[i] != '0) bin_count[i] = bin_count[i] - 1'b1;
        end
      end
      REQ_QUERY: begin
        total = running_sum + bin_count[bin];
        if (total > SUM_LIMIT) total = SUM_LIMIT;
        running_sum = SUM_W'(total);
        if (last) begin
          // a zero divisor counts as one
          den = (divisor == '0) ? 1 : divisor;
          val = (total * FULL_SCALE) / den;
          v.saturated   = (val > FULL_SCALE);
          v.probability = v.saturated ? PROB_W'(FULL_SCALE) : PROB_W'(val);
          block_values_q.push_back(v);
          running_sum = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bin_count[i]) bin_count[i] = '0;
      running_sum = '0;
      divisor     = TP_W'(1);
      block_values_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) divisor = cfg_wdata_i;
      if (res.valid && res.ready) begin
        if (block_values_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected: probability %0d saturated %0b",
                                    res.probability, res.saturated));
        end else begin
          want = block_values_q.pop_front();
          if (res.probability !== want.probability)
            report_mismatch($sformatf("probability %0d, expected %0d",
                                      res.probability, want.probability));
          if (res.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      res.saturated, want.saturated));
        end
      end
      if (req.valid && req.ready)
        predict_pixel(req.req_type, req.red, req.green, req.blue, req.last_of_block);
      pending_o    <= block_values_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> dv/tb_top.sv
// testbench top: clock, reset, pixel stimulus, result stalls and the verdict
`timescale 1ns / 100ps

module tb_top;
  import chbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         PHASES         = 6;
  localparam int         PHASE_ITEMS    = 225;
  localparam int         DRAIN_CYCLES   = 4200;
  localparam int         WATCHDOG_LIMIT = 30000;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [TP_W-1:0] cfg_wdata_i;
  int              fail_count;
  int              pending;
  int              sender_idle_pct;
  int              receiver_idle_pct;
  int              items_sent = 0;
  int              quiet_cycles = 0;
  logic [11:0]     palette [3];
  logic [TP_W-1:0] phase_divisor [PHASES] = '{TP_W'(1), TP_W'(0), {TP_W{1'b1}},
                                               TP_W'(1600), TP_W'(400), TP_W'(1048576)};

  chbp_req_if req_if ();
  chbp_res_if res_if ();

  colour_histogram_block_probability_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  chbp_backproject_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_if),
    .res          (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // run ends when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [23:0] px, input logic last);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.red           <= px[23:16];
    req_if.green         <= px[15:8];
    req_if.blue          <= px[7:0];
    req_if.last_of_block <= last;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // random pixel that falls in the given bin
  function automatic logic [23:0] pixel_in_bin(input logic [11:0] bin);
    logic [23:0] px;
    px = 24'($urandom);
    px[23:20] = bin[11:8];
    px[15:12] = bin[7:4];
    px[7:4]   = bin[3:0];
    return px;
  endfunction

  function automatic logic [23:0] query_pixel();
    if ($urandom_range(99) < 80) return pixel_in_bin(palette[$urandom_range(2)]);
    return 24'($urandom);
  endfunction

  task automatic settle_block();
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(REQ_QUERY, 24'h000000, 1'b1);
    send_item(REQ_TRAIN, 24'h000000, 1'b0);
    send_item(REQ_TRAIN, 24'hFFFFFF, 1'b1);
    send_item(REQ_QUERY, 24'hFFFFFF, 1'b0);
    // two counts over a divisor of one clips
    send_item(REQ_QUERY, 24'h0F0F0F, 1'b1);
    send_item(REQ_TRAIN, 24'h123456, 1'b0);
    send_item(REQ_QUERY, 24'h1F3F5F, 1'b1);
    send_item(REQ_UNUSED, 24'h123456, 1'b1);
    send_item(REQ_LEAK, 24'hA5A5A5, 1'b1);
    send_item(REQ_QUERY, 24'h123456, 1'b1);
    send_item(REQ_QUERY, 24'h000000, 1'b1);
    // leak over an empty histogram
    send_item(REQ_LEAK, 24'h5A5A5A, 1'b0);
    send_item(REQ_QUERY, 24'hFFFFFF, 1'b1);
    send_item(REQ_TRAIN, 24'hF00FA5, 1'b0);
    send_item(REQ_TRAIN, 24'hFA0AAF, 1'b0);
    send_item(REQ_QUERY, 24'hF50CA0, 1'b0);
    send_item(REQ_UNUSED, 24'hF00FA5, 1'b0);
    send_item(REQ_QUERY, 24'hF00FA5, 1'b1);
  endtask

  task automatic run_random(input int n_items);
    int          stop_at;
    int          sel;
    int          len;
    logic [11:0] bin;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        // training burst drives hot bins toward the count cap
        bin = palette[$urandom_range(2)];
        len = $urandom_range(5, 60);
        repeat (len) send_item(REQ_TRAIN, pixel_in_bin(bin), 1'($urandom));
      end else if (sel < 80) begin
        sel = $urandom_range(99);
        if (sel < 50) len = BLOCK_PIXELS;
        else if (sel < 80) len = $urandom_range(1, BLOCK_PIXELS - 1);
        else len = $urandom_range(BLOCK_PIXELS + 1, 40);
        for (int i = 0; i < len; i++) send_item(REQ_QUERY, query_pixel(), (i == len - 1));
      end else if (sel < 84) begin
        send_item(REQ_LEAK, 24'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(2'($urandom), 24'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_TRAIN;
    req_if.red           = '0;
    req_if.green         = '0;
    req_if.blue          = '0;
    req_if.last_of_block = 1'b0;
    sender_idle_pct      = 13;
    receiver_idle_pct    = 53;
    foreach (palette[i]) palette[i] = 12'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        req_if.valid <= 1'b0;
        settle_block();
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= phase_divisor[phase];
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
      end
      case (phase / 2)
        0: begin
          sender_idle_pct   = 13;
          receiver_idle_pct = 53;
        end
        1: begin
          sender_idle_pct   = 53;
          receiver_idle_pct = 13;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      run_random(PHASE_ITEMS);
    end
    req_if.valid <= 1'b0;
    settle_block();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/chbp_pkg.sv
rtl/chbp_req_if.sv
rtl/chbp_res_if.sv
rtl/chbp_hist_mem.sv
rtl/chbp_div.sv
rtl/chbp_ctrl.sv
rtl/colour_histogram_block_probability_top.sv
dv/chbp_backproject_checker.sv
dv/tb_top.sv
